// File: rtl/gcct_pkg.sv
// ----------------------------------------------------------------------------
// gcct_pkg
// Shared widths, constants and types for the grid cell crossing time block.
// ----------------------------------------------------------------------------
package gcct_pkg;

  localparam int COORD_W       = 24;
  localparam int SPEED_W       = 20;
  localparam int TIME_W        = 32;
  localparam int CELL_BITS_DEF = 5;

  // Cell side is UNIT_PER_GRID << CELL_BITS input units
  localparam int UNIT_PER_GRID = 1600;
  localparam int MS_PER_S      = 1000;

  // x / 1600 == (x >> 6) / 25; the divide by 25 is a reciprocal multiply
  localparam int PRE_SHIFT   = 6;
  localparam int RECIP_SHIFT = 23;
  localparam int RECIP       = 335545;   // ceil(2^23 / 25)

  localparam int SQ_W       = 50;        // dx^2 + dz^2 and root work width
  localparam int SQRT_STEPS = 25;        // one result bit per stage
  localparam int DIST_W     = 25;
  localparam int DEN_W      = SPEED_W + COORD_W;
  localparam int NUM_W      = 59;        // dist * num * 1000
  localparam int DIV_STEPS  = TIME_W;
  localparam int REM_W      = DEN_W + 1;

  // Data that rides along the root stages
  typedef struct packed {
    logic                 have;
    logic [COORD_W-1:0]   bn;
    logic [COORD_W-1:0]   bd;
    logic [SPEED_W-1:0]   speed;
  } side_t;

endpackage

// File: rtl/gcct_if.sv
// ----------------------------------------------------------------------------
// gcct_if
// Valid/ready channels for queries and results.
// ----------------------------------------------------------------------------
interface gcct_query_if;
  logic                          valid;
  logic                          ready;
  logic [gcct_pkg::COORD_W-1:0]  start_x;
  logic [gcct_pkg::COORD_W-1:0]  start_z;
  logic [gcct_pkg::COORD_W-1:0]  target_x;
  logic [gcct_pkg::COORD_W-1:0]  target_z;
  logic [gcct_pkg::SPEED_W-1:0]  move_speed;

  modport source(output valid, start_x, start_z, target_x, target_z, move_speed,
                 input ready);
  modport sink(input valid, start_x, start_z, target_x, target_z, move_speed,
               output ready);
endinterface

interface gcct_result_if;
  logic                         valid;
  logic                         ready;
  logic                         crosses;
  logic [gcct_pkg::TIME_W-1:0]  change_time_ms;

  modport source(output valid, crosses, change_time_ms, input ready);
  modport sink(input valid, crosses, change_time_ms, output ready);
endinterface

// File: rtl/grid_cell_crossing_time.sv
// ----------------------------------------------------------------------------
// grid_cell_crossing_time
// Time until a straight path leaves the grid cell that holds its start point.
// ----------------------------------------------------------------------------
//
//  channel   dir  fields
//  query     in   start_x, start_z, target_x, target_z, move_speed
//  result    out  crosses, change_time_ms
//
//  One item per cycle sustained while the output is not stalled. Depth is
//  set by the root (25 stages, one bit each) and the quotient (32 stages,
//  one bit each), plus lookup, edge, pick, product, setup and output stages.
//  Reset clears only the valid bits. The whole pipe advances when the output
//  register is empty or taken, so a stall freezes every stage in place.
//
//  Flow: cell lookup -> edge fractions + squares -> cross products + sum
//        -> pick smallest fraction -> isqrt -> num/den products -> divide
//        -> +1 and saturate.
// ----------------------------------------------------------------------------
module grid_cell_crossing_time #(
  parameter int CELL_BITS = gcct_pkg::CELL_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  gcct_query_if.sink       query,
  gcct_result_if.source    result
);

  localparam int CW        = gcct_pkg::COORD_W;
  localparam int QW        = 14;                 // (2^24 / 1600) fits
  localparam int EW        = CW + 1;             // edge positions
  localparam int CELL_SIZE = gcct_pkg::UNIT_PER_GRID << CELL_BITS;
  localparam int YW        = CW - gcct_pkg::PRE_SHIFT;
  localparam int RW        = 19;                 // reciprocal width
  localparam int PW        = YW + RW;

  // Global advance: output register empty or being taken
  logic adv;
  assign adv         = !result.valid || result.ready;
  assign query.ready = adv;

  // --------------------------------------------------------------------------
  // S1: cell index (divide by 1600), distances and directions
  // --------------------------------------------------------------------------
  logic                 s1_vld;
  logic [CW-1:0]        s1_sx, s1_sz, s1_dx, s1_dz;
  logic [QW-1:0]        s1_qx, s1_qz;
  logic                 s1_incx, s1_incz, s1_mvx, s1_mvz;
  logic [gcct_pkg::SPEED_W-1:0] s1_speed;
  logic [PW-1:0]        px_div, pz_div;

  assign px_div = PW'(query.start_x[CW-1:gcct_pkg::PRE_SHIFT]) * PW'(gcct_pkg::RECIP);
  assign pz_div = PW'(query.start_z[CW-1:gcct_pkg::PRE_SHIFT]) * PW'(gcct_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= query.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sx    <= query.start_x;
      s1_sz    <= query.start_z;
      s1_qx    <= px_div[gcct_pkg::RECIP_SHIFT +: QW];
      s1_qz    <= pz_div[gcct_pkg::RECIP_SHIFT +: QW];
      s1_incx  <= query.target_x > query.start_x;
      s1_incz  <= query.target_z > query.start_z;
      s1_mvx   <= query.target_x != query.start_x;
      s1_mvz   <= query.target_z != query.start_z;
      s1_dx    <= (query.target_x > query.start_x) ? query.target_x - query.start_x
                                                   : query.start_x - query.target_x;
      s1_dz    <= (query.target_z > query.start_z) ? query.target_z - query.start_z
                                                   : query.start_z - query.target_z;
      s1_speed <= query.move_speed;
    end
  end

  // --------------------------------------------------------------------------
  // S2: edge toward the target on each axis, squares of the deltas
  // --------------------------------------------------------------------------
  // Distance from start to the cell edge the path heads for
  function automatic logic [EW-1:0] edge_num(input logic [CW-1:0] s,
                                             input logic [QW-1:0] q,
                                             input logic          inc);
    logic [QW-1:0] q_al;
    logic [EW-1:0] left;
    logic [EW-1:0] right;
    q_al  = (q >> CELL_BITS) << CELL_BITS;
    left  = EW'(q_al) * EW'(gcct_pkg::UNIT_PER_GRID);
    right = left + EW'(CELL_SIZE);
    edge_num = inc ? (right - EW'(s)) : (EW'(s) - left);
  endfunction

  logic [EW-1:0] nx_c, nz_c;
  assign nx_c = edge_num(s1_sx, s1_qx, s1_incx);
  assign nz_c = edge_num(s1_sz, s1_qz, s1_incz);

  logic                 s2_vld, s2_okx, s2_okz;
  logic [CW-1:0]        s2_nx, s2_nz, s2_dx, s2_dz;
  logic [2*CW-1:0]      s2_sqx, s2_sqz;
  logic [gcct_pkg::SPEED_W-1:0] s2_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // a start on the edge gives a zero fraction, which does not count
      s2_okx   <= s1_mvx && (nx_c != '0) && (nx_c <= EW'(s1_dx));
      s2_okz   <= s1_mvz && (nz_c != '0) && (nz_c <= EW'(s1_dz));
      s2_nx    <= nx_c[CW-1:0];
      s2_nz    <= nz_c[CW-1:0];
      s2_dx    <= s1_dx;
      s2_dz    <= s1_dz;
      s2_sqx   <= (2*CW)'(s1_dx) * (2*CW)'(s1_dx);
      s2_sqz   <= (2*CW)'(s1_dz) * (2*CW)'(s1_dz);
      s2_speed <= s1_speed;
    end
  end

  // --------------------------------------------------------------------------
  // S3: cross products for the fraction compare, sum of squares
  // --------------------------------------------------------------------------
  logic                 s3_vld, s3_okx, s3_okz;
  logic [CW-1:0]        s3_nx, s3_nz, s3_dx, s3_dz;
  logic [2*CW-1:0]      s3_px, s3_pz;
  logic [gcct_pkg::SQ_W-1:0] s3_sum;
  logic [gcct_pkg::SPEED_W-1:0] s3_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_okx   <= s2_okx;
      s3_okz   <= s2_okz;
      s3_nx    <= s2_nx;
      s3_nz    <= s2_nz;
      s3_dx    <= s2_dx;
      s3_dz    <= s2_dz;
      s3_px    <= (2*CW)'(s2_nx) * (2*CW)'(s2_dz);
      s3_pz    <= (2*CW)'(s2_nz) * (2*CW)'(s2_dx);
      s3_sum   <= gcct_pkg::SQ_W'(s2_sqx) + gcct_pkg::SQ_W'(s2_sqz);
      s3_speed <= s2_speed;
    end
  end

  // --------------------------------------------------------------------------
  // S4 / root stage 0: pick the smallest fraction (X wins a tie)
  // Root: one result bit per stage, restoring method
  // --------------------------------------------------------------------------
  logic                       sq_vld [0:gcct_pkg::SQRT_STEPS];
  logic [gcct_pkg::SQ_W-1:0]  sq_v   [0:gcct_pkg::SQRT_STEPS];
  logic [gcct_pkg::SQ_W-1:0]  sq_r   [0:gcct_pkg::SQRT_STEPS];
  gcct_pkg::side_t            sq_sd  [0:gcct_pkg::SQRT_STEPS];

  logic take_z;
  assign take_z = s3_okz && (!s3_okx || (s3_pz < s3_px));

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (adv) begin
      sq_vld[0] <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_v[0]        <= s3_sum;
      sq_r[0]        <= '0;
      sq_sd[0].have  <= s3_okx || s3_okz;
      sq_sd[0].bn    <= take_z ? s3_nz : s3_nx;
      sq_sd[0].bd    <= take_z ? s3_dz : s3_dx;
      sq_sd[0].speed <= s3_speed;
    end
  end

  for (genvar k = 0; k < gcct_pkg::SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [gcct_pkg::SQ_W-1:0] BIT =
      gcct_pkg::SQ_W'(1) << (2 * (gcct_pkg::SQRT_STEPS - 1 - k));
    logic [gcct_pkg::SQ_W-1:0] trial;
    assign trial = sq_r[k] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else if (adv) begin
        sq_vld[k+1] <= sq_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_sd[k+1] <= sq_sd[k];
        if (sq_v[k] >= trial) begin
          sq_v[k+1] <= sq_v[k] - trial;
          sq_r[k+1] <= (sq_r[k] >> 1) + BIT;
        end else begin
          sq_v[k+1] <= sq_v[k];
          sq_r[k+1] <= sq_r[k] >> 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // M1, M2: numerator dist * bn * 1000, denominator speed * bd
  // --------------------------------------------------------------------------
  localparam int P1_W = gcct_pkg::DIST_W + CW;

  logic                         m1_vld, m1_have, m2_vld, m2_have;
  logic [P1_W-1:0]              m1_p;
  logic [gcct_pkg::DEN_W-1:0]   m1_den, m2_den;
  logic [gcct_pkg::NUM_W-1:0]   m2_num;
  gcct_pkg::side_t              sq_last;

  assign sq_last = sq_sd[gcct_pkg::SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
    end else if (adv) begin
      m1_vld <= sq_vld[gcct_pkg::SQRT_STEPS];
      m2_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_have <= sq_last.have;
      m1_p    <= P1_W'(sq_r[gcct_pkg::SQRT_STEPS][gcct_pkg::DIST_W-1:0]) * P1_W'(sq_last.bn);
      m1_den  <= gcct_pkg::DEN_W'(sq_last.speed) * gcct_pkg::DEN_W'(sq_last.bd);
      m2_have <= m1_have;
      m2_num  <= gcct_pkg::NUM_W'(m1_p) * gcct_pkg::NUM_W'(gcct_pkg::MS_PER_S);
      m2_den  <= m1_den;
    end
  end

  // --------------------------------------------------------------------------
  // Divide: quotient >= 2^32 is flagged up front, then one bit per stage
  // --------------------------------------------------------------------------
  localparam int HI_W = gcct_pkg::NUM_W - gcct_pkg::TIME_W;

  logic                          dv_vld  [0:gcct_pkg::DIV_STEPS];
  logic                          dv_have [0:gcct_pkg::DIV_STEPS];
  logic                          dv_ovf  [0:gcct_pkg::DIV_STEPS];
  logic [gcct_pkg::REM_W-1:0]    dv_r    [0:gcct_pkg::DIV_STEPS];
  logic [gcct_pkg::TIME_W-1:0]   dv_n    [0:gcct_pkg::DIV_STEPS];
  logic [gcct_pkg::TIME_W-1:0]   dv_q    [0:gcct_pkg::DIV_STEPS];
  logic [gcct_pkg::DEN_W-1:0]    dv_den  [0:gcct_pkg::DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (adv) begin
      dv_vld[0] <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_have[0] <= m2_have;
      // zero speed lands here too
      dv_ovf[0]  <= gcct_pkg::DEN_W'(m2_num[gcct_pkg::NUM_W-1 -: HI_W]) >= m2_den;
      dv_r[0]    <= gcct_pkg::REM_W'(m2_num[gcct_pkg::NUM_W-1 -: HI_W]);
      dv_n[0]    <= m2_num[gcct_pkg::TIME_W-1:0];
      dv_q[0]    <= '0;
      dv_den[0]  <= m2_den;
    end
  end

  for (genvar k = 0; k < gcct_pkg::DIV_STEPS; k++) begin : g_div
    logic [gcct_pkg::REM_W-1:0] sh;
    logic                       fit;
    assign sh  = {dv_r[k][gcct_pkg::REM_W-2:0], dv_n[k][gcct_pkg::TIME_W-1]};
    assign fit = sh >= gcct_pkg::REM_W'(dv_den[k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k+1] <= 1'b0;
      end else if (adv) begin
        dv_vld[k+1] <= dv_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_have[k+1] <= dv_have[k];
        dv_ovf[k+1]  <= dv_ovf[k];
        dv_den[k+1]  <= dv_den[k];
        dv_n[k+1]    <= dv_n[k] << 1;
        dv_q[k+1]    <= {dv_q[k][gcct_pkg::TIME_W-2:0], fit};
        dv_r[k+1]    <= fit ? sh - gcct_pkg::REM_W'(dv_den[k]) : sh;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: +1 and saturate, zero when no crossing
  // --------------------------------------------------------------------------
  localparam int LD = gcct_pkg::DIV_STEPS;

  logic [gcct_pkg::TIME_W-1:0] time_c;

  always_comb begin
    if (!dv_have[LD]) begin
      time_c = '0;
    end else if (dv_ovf[LD] || (&dv_q[LD])) begin
      time_c = '1;
    end else begin
      time_c = dv_q[LD] + gcct_pkg::TIME_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= dv_vld[LD];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.crosses        <= dv_have[LD];
      result.change_time_ms <= time_c;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_cross_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.crosses |-> result.change_time_ms == '0)
    else $error("no-crossing result with nonzero time");

  a_cross_nonzero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.crosses |-> result.change_time_ms != '0)
    else $error("crossing result with zero time");

  a_frac_le_one: assert property (@(posedge clk) disable iff (rst)
    sq_vld[0] && sq_sd[0].have |-> (sq_sd[0].bd != '0) && (sq_sd[0].bn <= sq_sd[0].bd))
    else $error("selected fraction outside (0,1]");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    dv_vld[0] && !dv_ovf[0] |-> dv_r[0] < gcct_pkg::REM_W'(dv_den[0]))
    else $error("divider start remainder not below divisor");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv && dv_vld[LD] |=> dv_vld[LD] && $stable(dv_q[LD]))
    else $error("last divider stage changed during stall");

endmodule

// File: tb/grid_cell_crossing_time_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_cell_crossing_time_tb
// Self-checking bench for the grid cell crossing time pipeline. A local
// predictor works out the expected crossing flag and time for every
// accepted query. A checker compares each result item, in order, against
// those predictions. Traffic mixes directed corner cases, short
// neighbor-cell paths, long paths and noise, under random idling on both
// sides and a long output hold-off.
// ----------------------------------------------------------------------------
module grid_cell_crossing_time_tb;

  localparam int       COORD_W       = gcct_pkg::COORD_W;
  localparam int       SPEED_W       = gcct_pkg::SPEED_W;
  localparam int       TIME_W        = gcct_pkg::TIME_W;
  localparam int       UNIT_PER_GRID = gcct_pkg::UNIT_PER_GRID;
  localparam int       MS_PER_S      = gcct_pkg::MS_PER_S;
  localparam int       CELL_BITS_DEF = gcct_pkg::CELL_BITS_DEF;

  localparam int       HALF_PERIOD = 10;
  localparam int       PIPE_LAT    = 64;
  localparam longint   CELL_SIDE   = longint'(UNIT_PER_GRID) << CELL_BITS_DEF;
  localparam logic [COORD_W-1:0] COORD_MAX = '1;
  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
  localparam longint   TIME_SAT    = 64'hFFFF_FFFF;
  localparam int       RAND_ITEMS  = 1440;

  typedef struct {
    logic              crosses;
    logic [TIME_W-1:0] change_time_ms;
  } crossing_t;

  logic clk;
  logic rst;

  gcct_query_if  query();
  gcct_result_if result();

  grid_cell_crossing_time dut (
    .clk    (clk),
    .rst    (rst),
    .query  (query.sink),
    .result (result.source)
  );

  // Expected crossings, oldest first
  crossing_t pending_crossings[$];
  int        error_count = 0;
  int        hold_off_cycles = 0;   // one-shot long stall request for the receiver

  always begin
    clk = 1'b1;
    #HALF_PERIOD;
    clk = 1'b0;
    #HALF_PERIOD;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Fold one edge into the running smallest fraction bn/bd.
  // Counts only 0 < (s-a)/(s-t) <= 1.
  function automatic void fold_edge(input longint s, input longint t, input longint a,
                                    inout bit found, inout longint bn, inout longint bd);
    longint n;
    longint d;
    n = s - a;
    d = s - t;
    if (n == 0 || d == 0) return;
    if ((n > 0) != (d > 0)) return;
    if (n < 0) begin
      n = -n;
      d = -d;
    end
    if (n > d) return;
    if (!found || n * bd < bn * d) begin
      found = 1'b1;
      bn    = n;
      bd    = d;
    end
  endfunction

  function automatic crossing_t predict_crossing(
      logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sz,
      logic [COORD_W-1:0] tx, logic [COORD_W-1:0] tz,
      logic [SPEED_W-1:0] speed);
    crossing_t       r;
    longint          cell_x0;
    longint          cell_z0;
    bit              found;
    longint          bn;
    longint          bd;
    longint unsigned dx;
    longint unsigned dz;
    longint unsigned path_len;
    longint unsigned quot;
    found   = 1'b0;
    bn      = 0;
    bd      = 1;
    cell_x0 = ((longint'(sx) / UNIT_PER_GRID) >> CELL_BITS_DEF) * CELL_SIDE;
    cell_z0 = ((longint'(sz) / UNIT_PER_GRID) >> CELL_BITS_DEF) * CELL_SIDE;
    fold_edge(longint'(sx), longint'(tx), cell_x0, found, bn, bd);
    fold_edge(longint'(sx), longint'(tx), cell_x0 + CELL_SIDE, found, bn, bd);
    fold_edge(longint'(sz), longint'(tz), cell_z0, found, bn, bd);
    fold_edge(longint'(sz), longint'(tz), cell_z0 + CELL_SIDE, found, bn, bd);
    if (!found) begin
      r.crosses        = 1'b0;
      r.change_time_ms = '0;
      return r;
    end
    dx       = (sx > tx) ? sx - tx : tx - sx;
    dz       = (sz > tz) ? sz - tz : tz - sz;
    path_len = int_sqrt(dx * dx + dz * dz);
    r.crosses = 1'b1;
    if (speed == 0) begin
      r.change_time_ms = TIME_SAT[TIME_W-1:0];
    end else begin
      quot = (path_len * longint'(bn) * MS_PER_S) / (longint'(speed) * longint'(bd));
      r.change_time_ms = (quot >= TIME_SAT) ? TIME_SAT[TIME_W-1:0] : TIME_W'(quot + 1);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one query item, with a random lead-in gap
  // --------------------------------------------------------------------------
  task automatic send_query(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sz,
                            input logic [COORD_W-1:0] tx, input logic [COORD_W-1:0] tz,
                            input logic [SPEED_W-1:0] speed);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk);
      query.valid <= 1'b0;
    end
    @(negedge clk);
    query.valid      <= 1'b1;
    query.start_x    <= sx;
    query.start_z    <= sz;
    query.target_x   <= tx;
    query.target_z   <= tz;
    query.move_speed <= speed;
    do @(posedge clk); while (!query.ready);
    pending_crossings.push_back(predict_crossing(sx, sz, tx, tz, speed));
  endtask

  task automatic idle_sender();
    @(negedge clk);
    query.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    idle_sender();
    while (pending_crossings.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus an occasional long hold-off
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    result.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      end
      repeat (stall) begin
        result.ready <= 1'b0;
        @(negedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
      @(negedge clk);
    end
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("%0t ERROR %s", $realtime, what);
  endtask

  // Checker: every accepted result item against the oldest prediction
  always @(posedge clk) begin
    crossing_t exp_item;
    if (!rst && result.valid && result.ready) begin
      if (pending_crossings.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        exp_item = pending_crossings.pop_front();
        if (result.crosses !== exp_item.crosses)
          report_mismatch($sformatf("crosses got %b exp %b",
                                    result.crosses, exp_item.crosses));
        if (result.change_time_ms !== exp_item.change_time_ms)
          report_mismatch($sformatf("change_time_ms got %0d exp %0d",
                                    result.change_time_ms, exp_item.change_time_ms));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [COORD_W-1:0] clamp_coord(longint v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_MAX;
    return v[COORD_W-1:0];
  endfunction

  function automatic logic [SPEED_W-1:0] rand_speed();
    case ($urandom_range(0, 3))
      0:       return SPEED_W'($urandom_range(1, 64));
      1:       return SPEED_W'($urandom_range(1, SPEED_MAX));
      default: return SPEED_W'($urandom_range(1, 4096));
    endcase
  endfunction

  // Mostly paths to a nearby cell; some long, some edge-aligned, some noise
  task automatic send_random_query();
    logic [COORD_W-1:0] sx, sz, tx, tz;
    int kind;
    kind = $urandom_range(0, 9);
    sx = COORD_W'($urandom_range(0, COORD_MAX));
    sz = COORD_W'($urandom_range(0, COORD_MAX));
    if (kind == 0) begin
      // start snapped onto a cell corner or edge
      sx = clamp_coord((longint'(sx) / CELL_SIDE) * CELL_SIDE);
      if ($urandom_range(0, 1)) sz = clamp_coord((longint'(sz) / CELL_SIDE) * CELL_SIDE);
    end
    case (kind)
      1: begin
        tx = COORD_W'($urandom_range(0, COORD_MAX));
        tz = COORD_W'($urandom_range(0, COORD_MAX));
      end
      2: begin
        // target exactly on a neighboring edge
        tx = clamp_coord(((longint'(sx) / CELL_SIDE) + $urandom_range(0, 1)) * CELL_SIDE);
        tz = sz;
      end
      3: begin
        tx = sx;
        tz = clamp_coord(longint'(sz) + $signed($urandom_range(0, 8)) - 4);
      end
      default: begin
        tx = clamp_coord(longint'(sx) + longint'($urandom_range(0, 32'(4 * CELL_SIDE)))
                         - 2 * CELL_SIDE);
        tz = clamp_coord(longint'(sz) + longint'($urandom_range(0, 32'(4 * CELL_SIDE)))
                         - 2 * CELL_SIDE);
      end
    endcase
    send_query(sx, sz, tx, tz, rand_speed());
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    // zero path length: no crossing
    send_query(24'd1000, 24'd2000, 24'd1000, 24'd2000, 20'd16);
    // start on left edge heading left: edge at start does not count
    send_query(COORD_W'(CELL_SIDE), 24'd100, COORD_W'(CELL_SIDE - 5), 24'd100, 20'd16);
    // start on left edge heading right across the right edge
    send_query(COORD_W'(CELL_SIDE), 24'd100, COORD_W'(3 * CELL_SIDE), 24'd100, 20'd16);
    // target exactly on right edge: fraction of one counts
    send_query(24'd10, 24'd10, COORD_W'(CELL_SIDE), 24'd10, 20'd160);
    // inside one cell: no crossing
    send_query(24'd10, 24'd10, 24'd500, 24'd900, 20'd160);
    // full span of both axes, slowest and fastest speeds
    send_query(COORD_MAX, COORD_MAX, 24'd0, 24'd0, 20'd1);
    send_query(24'd0, 24'd0, COORD_MAX, COORD_MAX, SPEED_MAX);
    send_query(COORD_MAX, 24'd0, 24'd0, COORD_MAX, 20'd1);
    send_query(24'd0, COORD_MAX, COORD_MAX, 24'd0, SPEED_MAX);
    // long path, speed one
    send_query(24'd1, 24'd1, COORD_MAX, 24'd1, 20'd1);
    // zero speed: infinite time
    send_query(24'd100, 24'd100, COORD_W'(3 * CELL_SIDE), 24'd100, 20'd0);
    // diagonal through a corner
    send_query(COORD_W'(CELL_SIDE / 2), COORD_W'(CELL_SIDE / 2),
               COORD_W'(CELL_SIDE * 3 / 2), COORD_W'(CELL_SIDE * 3 / 2), 20'd33);
    // one unit steps over an edge on each side
    send_query(COORD_W'(CELL_SIDE - 1), 24'd5, COORD_W'(CELL_SIDE), 24'd5, 20'd1);
    send_query(COORD_W'(CELL_SIDE), 24'd5, COORD_W'(CELL_SIDE - 1), 24'd5, 20'd1);
    send_query(24'd5, COORD_W'(CELL_SIDE - 1), 24'd5, COORD_W'(CELL_SIDE), 20'd1);
    send_query(24'd5, COORD_W'(2 * CELL_SIDE), 24'd5, COORD_W'(2 * CELL_SIDE - 1), 20'd1);
    // top cell, heading down into the last full cell
    send_query(COORD_MAX, COORD_MAX, COORD_MAX - 24'd1, COORD_MAX - 24'd70000, 20'd7);
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_random_query();
  endtask

  // Receiver holds off long enough to fill the pipe and stall the input
  task automatic test_output_backpressure();
    wait_drained();
    hold_off_cycles = 3 * PIPE_LAT;
    repeat (PIPE_LAT + 40) send_random_query();
  endtask

  // Sender pauses until every result is back, then resumes
  task automatic test_drain_pause();
    wait_drained();
    repeat (PIPE_LAT + 8) @(posedge clk);
    test_random_traffic(50);
  endtask

  initial begin
    rst              = 1'b1;
    query.valid      = 1'b0;
    query.start_x    = '0;
    query.start_z    = '0;
    query.target_x   = '0;
    query.target_z   = '0;
    query.move_speed = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_traffic(RAND_ITEMS / 2);
    test_output_backpressure();
    test_drain_pause();
    test_random_traffic(RAND_ITEMS / 2);

    wait_drained();
    repeat (PIPE_LAT + 16) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: files.f
rtl/gcct_pkg.sv
rtl/gcct_if.sv
rtl/grid_cell_crossing_time.sv
tb/grid_cell_crossing_time_tb.sv
